// ----- rtl/core/nps_pkg.sv -----
// Shared types and constants of the nearest point search block.
package nps_pkg;

    localparam int MAX_POINTS_DEF = 1024;

    localparam int REQ_W     = 2;
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIST_W    = SQ_W + 1;
    localparam int IDX_OUT_W = 10;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // x and y of one stored point, packed into one RAM word
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

endpackage

// ----- rtl/core/nps_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module nps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/nps_sq_dist.sv -----
// Three-stage squared distance pipeline: difference, square, sum.
module nps_sq_dist import nps_pkg::*; #(
    parameter int IDX_W = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      tag_valid,
    input  logic [IDX_W-1:0]          tag_idx,
    input  point_t                    point,
    input  logic signed [COORD_W-1:0] qx,
    input  logic signed [COORD_W-1:0] qy,
    output logic                      dist_valid,
    output logic [IDX_W-1:0]          dist_idx,
    output logic [DIST_W-1:0]         dist_sq,
    output logic                      busy
);

    logic             d_valid_reg;
    logic             m_valid_reg;
    logic             s_valid_reg;
    logic [IDX_W-1:0] d_idx_reg;
    logic [IDX_W-1:0] m_idx_reg;
    logic [IDX_W-1:0] s_idx_reg;
    logic [DIFF_W-1:0] dx_reg;
    logic [DIFF_W-1:0] dy_reg;
    logic [SQ_W-1:0]   sx_reg;
    logic [SQ_W-1:0]   sy_reg;
    logic [DIST_W-1:0] sum_reg;

    logic signed [DIFF_W-1:0] sub_x;
    logic signed [DIFF_W-1:0] sub_y;
    logic [DIFF_W-1:0]        dx_next;
    logic [DIFF_W-1:0]        dy_next;
    logic [2*DIFF_W-1:0]      sx_full;
    logic [2*DIFF_W-1:0]      sy_full;

    // magnitudes stay below 2^32, so squares fit in 64 bits
    always_comb
    begin
        sub_x   = {point.x[COORD_W-1], point.x} - {qx[COORD_W-1], qx};
        sub_y   = {point.y[COORD_W-1], point.y} - {qy[COORD_W-1], qy};
        dx_next = sub_x[DIFF_W-1] ? DIFF_W'(-sub_x) : DIFF_W'(sub_x);
        dy_next = sub_y[DIFF_W-1] ? DIFF_W'(-sub_y) : DIFF_W'(sub_y);
        sx_full = dx_reg * dx_reg;
        sy_full = dy_reg * dy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= tag_valid;
            m_valid_reg <= d_valid_reg;
            s_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_idx_reg <= tag_idx;
        m_idx_reg <= d_idx_reg;
        s_idx_reg <= m_idx_reg;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        sx_reg    <= sx_full[SQ_W-1:0];
        sy_reg    <= sy_full[SQ_W-1:0];
        sum_reg   <= {1'b0, sx_reg} + {1'b0, sy_reg};
    end

    assign dist_valid = s_valid_reg;
    assign dist_idx   = s_idx_reg;
    assign dist_sq    = sum_reg;
    assign busy       = d_valid_reg | m_valid_reg | s_valid_reg;

endmodule

// ----- rtl/core/nearest_point_search_top.sv -----
// Top level of the nearest point search block: point table, scan control, result register.
//
// The block holds up to MAX_POINTS 2-D points (signed 32-bit coordinates) in one
// RAM, x and y side by side in one word. A clear request (req_type 0) or an
// append request (req_type 1) is taken in the idle state; an append to a full table
// is dropped, and neither gives a result. Request code 3 is ignored. A query request
// (req_type 2) reads the stored points through the single RAM read port, one point
// per cycle, and runs each through a three-stage squared distance pipeline (exact
// 65-bit distance) followed by a compare against the running minimum; the lowest
// slot wins a tie. The input stays stalled for the whole query: while the stored
// points are read, while the read and distance stages drain, and while the result
// is loaded. An empty table skips the scan and goes straight to the result, with
// found 0 and nearest_index 0. The result sits in an output register; new clear and
// append requests are taken while it waits, and a following query holds its result
// until the previous one is taken. nearest_index carries the low 10 bits of the slot.
// The RAM needs no initialization: only slots below the point count are read.
module nearest_point_search_top import nps_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int CW = $clog2(MAX_POINTS + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [REQ_W-1:0]          req_type,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [IDX_OUT_W-1:0]      nearest_index,
    output logic                      found
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   scan_reg, scan_next;
    logic            rd_valid_reg, rd_valid_next;
    logic [AW-1:0]   rd_idx_reg, rd_idx_next;
    logic            have_best_reg, have_best_next;
    logic            out_valid_reg, out_valid_next;
    logic [IDX_OUT_W-1:0] nearest_index_reg;
    logic                 found_reg;

    // payload registers, no reset
    logic signed [COORD_W-1:0] qx_reg;
    logic signed [COORD_W-1:0] qy_reg;
    logic [DIST_W-1:0]         best_dist_reg;
    logic [AW-1:0]             best_idx_reg;

    logic          accept;
    req_t          req;
    logic          ram_we;
    logic          ram_re;
    point_t        wr_point;
    point_t        rd_point;
    logic          dist_valid;
    logic [AW-1:0] dist_idx;
    logic [DIST_W-1:0] dist_sq;
    logic          pipe_busy;
    logic          take_best;
    logic          load_result;
    logic [AW+IDX_OUT_W-1:0] best_wide;

    assign accept   = in_valid && !in_stall;
    assign req      = req_t'(req_type);
    assign in_stall = (state_reg != ST_IDLE);
    assign wr_point = '{x: pos_x, y: pos_y};

    nps_ram #(
        .WIDTH ($bits(point_t)),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_point),
        .re    (ram_re),
        .raddr (scan_reg[AW-1:0]),
        .rdata (rd_point)
    );

    nps_sq_dist #(
        .IDX_W (AW)
    ) u_sq_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag_valid  (rd_valid_reg),
        .tag_idx    (rd_idx_reg),
        .point      (rd_point),
        .qx         (qx_reg),
        .qy         (qy_reg),
        .dist_valid (dist_valid),
        .dist_idx   (dist_idx),
        .dist_sq    (dist_sq),
        .busy       (pipe_busy)
    );

    // strict less-than keeps the lowest slot on ties
    assign take_best   = dist_valid && (!have_best_reg || (dist_sq < best_dist_reg));
    assign load_result = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    assign best_wide   = {{IDX_OUT_W{1'b0}}, best_idx_reg};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        rd_valid_next  = 1'b0;
        rd_idx_next    = rd_idx_reg;
        have_best_next = have_best_reg | dist_valid;
        out_valid_next = out_valid_reg && out_stall;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req)
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        REQ_APPEND:
                        begin
                            if (count_reg < CW'(MAX_POINTS))
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_QUERY:
                        begin
                            have_best_next = 1'b0;
                            scan_next      = '0;
                            state_next     = (count_reg == '0) ? ST_FINISH : ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                ram_re        = 1'b1;
                rd_valid_next = 1'b1;
                rd_idx_next   = scan_reg[AW-1:0];
                if (scan_reg == count_reg - CW'(1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load_result)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            count_reg         <= '0;
            scan_reg          <= '0;
            rd_valid_reg      <= 1'b0;
            rd_idx_reg        <= '0;
            have_best_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            nearest_index_reg <= '0;
            found_reg         <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            rd_valid_reg  <= rd_valid_next;
            rd_idx_reg    <= rd_idx_next;
            have_best_reg <= have_best_next;
            out_valid_reg <= out_valid_next;
            if (load_result)
            begin
                found_reg         <= have_best_reg;
                nearest_index_reg <= have_best_reg ? best_wide[IDX_OUT_W-1:0] : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (req == REQ_QUERY))
        begin
            qx_reg <= pos_x;
            qy_reg <= pos_y;
        end
        if (take_best)
        begin
            best_dist_reg <= dist_sq;
            best_idx_reg  <= dist_idx;
        end
    end

    assign out_valid     = out_valid_reg;
    assign nearest_index = nearest_index_reg;
    assign found         = found_reg;

    // table fill never passes capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count above capacity");

    // distances only arrive while a query is in flight
    a_dist_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        dist_valid |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("distance result outside a query");

    // a query on an empty table goes straight to the result
    a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req == REQ_QUERY && count_reg == '0) |=> (state_reg == ST_FINISH))
        else $error("empty query did not finish at once");

    // a new result only comes out of the finish state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside finish state");

    // scan never reads past the stored points
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_reg < count_reg))
        else $error("scan address beyond point count");

endmodule
